// ===== rtl/http_chunked_stream_decoder_core_assert.svh =====
// Assertion macros for the chunked stream decoder.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef HTTP_CHUNKED_STREAM_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HCSD_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hcsd assertion failed");
`define HCSD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hcsd assertion failed");
`else
`define HCSD_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define HCSD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/hcsd_pkg.sv =====
package hcsd_pkg;

    localparam int SIZE_BITS = 32;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};
    localparam logic [SIZE_BITS-1:0] SIZE_TWO = SIZE_BITS'(2);

    localparam logic [3:0] PREFIX_LEN  = 4'd9;
    localparam logic [4:0] PATTERN_LEN = 5'd26;
    localparam logic [4:0] PATTERN_E_POS = 5'd9;

    localparam logic [9:0]  STATUS_OK        = 10'd200;
    localparam logic [9:0]  STATUS_UNAUTH    = 10'd401;
    localparam logic [9:0]  STATUS_NOT_FOUND = 10'd404;
    localparam logic [13:0] STATUS_SAT       = 14'd999;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LOW_E = 8'h65;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_CODE   = 3'd1,
        PH_HEADER = 3'd2,
        PH_SIZE   = 3'd3,
        PH_DATA   = 3'd4,
        PH_HALT   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD    = 2'd0,
        EV_HDR_OK     = 2'd1,
        EV_HDR_ERROR  = 2'd2,
        EV_CONFIG_END = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_PROTOCOL  = 2'd1,
        ERR_AUTH      = 2'd2,
        ERR_NOT_FOUND = 2'd3
    } err_code_t;

    typedef enum logic {
        CFG_REQUIRE_CHUNKED   = 1'b0,
        CFG_FALLBACK_ON_ERROR = 1'b1
    } cfg_reg_t;

    // One input word's results: nl_count newline bytes, then the main result.
    typedef struct packed {
        logic [1:0] nl_count;
        ev_kind_t   kind;
        logic [7:0] data;
        err_code_t  err;
        logic       backup;
    } res_desc_t;

    function automatic logic [7:0] status_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "H";
            4'd1:    ch = "T";
            4'd2:    ch = "T";
            4'd3:    ch = "P";
            4'd4:    ch = "/";
            4'd5:    ch = "1";
            4'd6:    ch = ".";
            4'd7:    ch = "1";
            4'd8:    ch = " ";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pattern_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "T";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "E";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            5'd17:   ch = ":";
            5'd18:   ch = " ";
            5'd19:   ch = "c";
            5'd20:   ch = "h";
            5'd21:   ch = "u";
            5'd22:   ch = "n";
            5'd23:   ch = "k";
            5'd24:   ch = "e";
            5'd25:   ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, c[3:0]};
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hcsd_parser.sv =====
module hcsd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  require_chunked,
    input  logic                  fallback_on_error,
    output logic                  emit,
    output hcsd_pkg::res_desc_t   desc
);
    import hcsd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [3:0]           prefix_pos_reg, prefix_pos_next;
    logic [9:0]           status_reg, status_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic [2:0]           blank_reg, blank_next;
    logic [4:0]           pattern_pos_reg, pattern_pos_next;
    logic                 chunked_reg, chunked_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic [1:0]           flags_reg, flags_next;
    logic [1:0]           held_reg, held_next;

    logic                 blank_hit;
    logic                 pat_match;
    logic [13:0]          status_prod;
    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] chunk_dec;

    always_comb
    begin
        phase_next       = phase_reg;
        prefix_pos_next  = prefix_pos_reg;
        status_next      = status_reg;
        digit_seen_next  = digit_seen_reg;
        blank_next       = blank_reg;
        pattern_pos_next = pattern_pos_reg;
        chunked_next     = chunked_reg;
        chunk_next       = chunk_reg;
        flags_next       = flags_reg;
        held_next        = held_reg;
        emit             = 1'b0;
        desc             = '{nl_count: 2'd0, kind: EV_PAYLOAD, data: 8'h00,
                             err: ERR_NONE, backup: 1'b0};
        blank_hit        = 1'b0;
        pat_match        = 1'b0;
        status_prod      = {4'd0, status_reg} * 14'd10 + {10'd0, data_byte[3:0]};
        hex              = hex_nibble(data_byte);
        chunk_dec        = chunk_reg;

        // Blank line and chunked header tracking run through the whole header.
        if (phase_reg == PH_PREFIX || phase_reg == PH_CODE || phase_reg == PH_HEADER)
        begin
            if (data_byte == CH_CR)
            begin
                blank_next = (blank_reg == 3'd2) ? 3'd3 : 3'd1;
            end
            else if (data_byte == CH_LF)
            begin
                if (blank_reg == 3'd2 || blank_reg == 3'd3 || blank_reg == 3'd4)
                begin
                    blank_next = 3'd0;
                    blank_hit  = 1'b1;
                end
                else
                begin
                    blank_next = (blank_reg == 3'd1) ? 3'd2 : 3'd4;
                end
            end
            else
            begin
                blank_next = 3'd0;
            end

            if (!chunked_reg && pattern_pos_reg < PATTERN_LEN)
            begin
                pat_match = (data_byte == pattern_char(pattern_pos_reg)) ||
                            (pattern_pos_reg == PATTERN_E_POS && data_byte == CH_LOW_E);
                if (pat_match)
                begin
                    pattern_pos_next = pattern_pos_reg + 5'd1;
                end
                else
                begin
                    pattern_pos_next = (data_byte == CH_T) ? 5'd1 : 5'd0;
                end
                if (pattern_pos_next >= PATTERN_LEN)
                begin
                    chunked_next = 1'b1;
                end
            end
        end

        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (prefix_pos_reg < PREFIX_LEN && data_byte == status_char(prefix_pos_reg))
                begin
                    prefix_pos_next = prefix_pos_reg + 4'd1;
                    if (prefix_pos_next >= PREFIX_LEN)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                else
                begin
                    emit        = 1'b1;
                    desc.kind   = EV_HDR_ERROR;
                    desc.err    = ERR_PROTOCOL;
                    phase_next  = PH_HALT;
                end
            end
            PH_CODE:
            begin
                if (data_byte >= "0" && data_byte <= "9")
                begin
                    status_next     = (status_prod > STATUS_SAT) ? STATUS_SAT[9:0]
                                                                 : status_prod[9:0];
                    digit_seen_next = 1'b1;
                end
                else if (!digit_seen_reg)
                begin
                    if (data_byte != CH_SPACE)
                    begin
                        emit       = 1'b1;
                        desc.kind  = EV_HDR_ERROR;
                        desc.err   = ERR_PROTOCOL;
                        phase_next = PH_HALT;
                    end
                end
                else if (status_reg == STATUS_OK)
                begin
                    phase_next = PH_HEADER;
                end
                else
                begin
                    emit        = 1'b1;
                    desc.kind   = EV_HDR_ERROR;
                    desc.backup = fallback_on_error;
                    if (status_reg == STATUS_UNAUTH)
                    begin
                        desc.err = ERR_AUTH;
                    end
                    else if (status_reg == STATUS_NOT_FOUND)
                    begin
                        desc.err = ERR_NOT_FOUND;
                    end
                    else
                    begin
                        desc.err = ERR_PROTOCOL;
                    end
                    phase_next = PH_HALT;
                end
            end
            PH_HEADER:
            begin
                if (blank_hit)
                begin
                    emit = 1'b1;
                    if (require_chunked && !chunked_next)
                    begin
                        desc.kind  = EV_HDR_ERROR;
                        desc.err   = ERR_PROTOCOL;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        desc.kind  = EV_HDR_OK;
                        phase_next = PH_SIZE;
                        chunk_next = '0;
                        flags_next = 2'b00;
                    end
                end
            end
            PH_SIZE:
            begin
                if (data_byte == CH_LF && flags_reg[1])
                begin
                    // Count the two closing bytes along with the payload.
                    chunk_next = (chunk_reg > (SIZE_MAX - SIZE_TWO)) ? SIZE_MAX
                                                                     : chunk_reg + SIZE_TWO;
                    flags_next = 2'b00;
                    phase_next = PH_DATA;
                end
                else
                begin
                    if (hex[4] && !flags_reg[0])
                    begin
                        chunk_next = (chunk_reg[SIZE_BITS-1 -: 4] != 4'd0) ? SIZE_MAX
                                   : {chunk_reg[SIZE_BITS-5:0], hex[3:0]};
                        flags_next[0] = flags_reg[0];
                    end
                    else
                    begin
                        flags_next[0] = 1'b1;
                    end
                    flags_next[1] = (data_byte == CH_CR);
                end
            end
            PH_DATA:
            begin
                if (chunk_reg > SIZE_TWO)
                begin
                    if (data_byte == CH_LF)
                    begin
                        if (held_reg == 2'd3)
                        begin
                            held_next = 2'd0;
                            emit      = 1'b1;
                            desc.kind = EV_CONFIG_END;
                        end
                        else
                        begin
                            held_next = held_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // Flush held newlines ahead of this byte.
                        emit          = 1'b1;
                        desc.nl_count = held_reg;
                        desc.kind     = EV_PAYLOAD;
                        desc.data     = data_byte;
                        held_next     = 2'd0;
                    end
                end
                if (chunk_reg != '0)
                begin
                    chunk_dec = chunk_reg - SIZE_BITS'(1);
                end
                chunk_next = chunk_dec;
                if (chunk_dec == '0)
                begin
                    phase_next = PH_SIZE;
                    flags_next = 2'b00;
                end
            end
            default:
            begin
                // Halted: drop every word until reset.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PREFIX;
            prefix_pos_reg  <= 4'd0;
            status_reg      <= 10'd0;
            digit_seen_reg  <= 1'b0;
            blank_reg       <= 3'd0;
            pattern_pos_reg <= 5'd0;
            chunked_reg     <= 1'b0;
            chunk_reg       <= '0;
            flags_reg       <= 2'b00;
            held_reg        <= 2'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            prefix_pos_reg  <= prefix_pos_next;
            status_reg      <= status_next;
            digit_seen_reg  <= digit_seen_next;
            blank_reg       <= blank_next;
            pattern_pos_reg <= pattern_pos_next;
            chunked_reg     <= chunked_next;
            chunk_reg       <= chunk_next;
            flags_reg       <= flags_next;
            held_reg        <= held_next;
        end
    end

endmodule

// ===== rtl/hcsd_out.sv =====
module hcsd_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  hcsd_pkg::res_desc_t   desc,
    output logic                  free,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [1:0]            event_kind,
    output logic [7:0]            payload_byte,
    output logic [1:0]            error_code,
    output logic                  use_backup,
    output logic                  last
);
    import hcsd_pkg::*;

    logic       valid_reg;
    res_desc_t  desc_reg;
    logic [1:0] nl_left_reg;
    logic       pop;
    logic       nl_pending;

    assign nl_pending = (nl_left_reg != 2'd0);
    assign pop        = valid_reg && !result_stall;
    assign free       = !valid_reg || (pop && !nl_pending);

    assign result_valid = valid_reg;
    assign event_kind   = nl_pending ? EV_PAYLOAD : desc_reg.kind;
    assign payload_byte = nl_pending ? CH_LF : desc_reg.data;
    assign error_code   = nl_pending ? ERR_NONE : desc_reg.err;
    assign use_backup   = nl_pending ? 1'b0 : desc_reg.backup;
    assign last         = !nl_pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            nl_left_reg <= 2'd0;
        end
        else if (load)
        begin
            valid_reg   <= 1'b1;
            nl_left_reg <= desc.nl_count;
        end
        else if (pop)
        begin
            if (nl_pending)
            begin
                nl_left_reg <= nl_left_reg - 2'd1;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
    end

endmodule

// ===== rtl/http_chunked_stream_decoder_core.sv =====
// Chunked HTTP response decoder, one response byte per input word.
// Input channel: data_valid / data_stall carry data_byte. A word is taken
// when data_valid is high and data_stall is low.
// Result channel: result_valid / result_stall carry event_kind, payload_byte,
// error_code, use_backup and last. last marks the final result of one byte.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is require_chunked, index 1 is fallback_on_error. cfg_ready is always high.
// A byte is registered in the input register, and its first result in the result register.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a byte that flushes held newlines holds
// the result register for all its results (up to four); the input side stalls meanwhile.
// A byte that gives no result never waits on the result register.
// When the receiver stalls, the current result holds and one more byte is
// buffered in the input register before data_stall rises.
// Reset clears the parser to the status line, drops any pending result and
// sets require_chunked to 1, fallback_on_error to 0.
`include "http_chunked_stream_decoder_core_assert.svh"

module http_chunked_stream_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] event_kind,
    output logic [7:0] payload_byte,
    output logic [1:0] error_code,
    output logic       use_backup,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);
    import hcsd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       require_chunked_reg;
    logic       fallback_reg;
    logic       emit;
    logic       out_free;
    logic       step;
    res_desc_t  desc;

    assign cfg_ready  = 1'b1;
    assign step       = in_valid_reg && (!emit || out_free);
    assign data_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (data_valid && !data_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
        begin
            in_byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_chunked_reg <= 1'b1;
            fallback_reg        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REQUIRE_CHUNKED:   require_chunked_reg <= cfg_data;
                CFG_FALLBACK_ON_ERROR: fallback_reg        <= cfg_data;
                default:               ;
            endcase
        end
    end

    hcsd_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .data_byte         (in_byte_reg),
        .require_chunked   (require_chunked_reg),
        .fallback_on_error (fallback_reg),
        .emit              (emit),
        .desc              (desc)
    );

    hcsd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && emit),
        .desc         (desc),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .event_kind   (event_kind),
        .payload_byte (payload_byte),
        .error_code   (error_code),
        .use_backup   (use_backup),
        .last         (last)
    );

    // A taken result that is not the last of its byte is followed by another.
    `HCSD_ASSERT_NEXT(a_more_follows, clk, rst_n, result_valid && !result_stall && !last, result_valid)
    // Only flushed newlines precede the final result of a byte.
    `HCSD_ASSERT_SAME(a_flush_is_newline, clk, rst_n, result_valid && !last, event_kind == EV_PAYLOAD && payload_byte == CH_LF)
    // A header error stands alone.
    `HCSD_ASSERT_SAME(a_error_alone, clk, rst_n, result_valid && event_kind == EV_HDR_ERROR, last)
    // The input side stalls only with a byte waiting in the input register.
    `HCSD_ASSERT_SAME(a_stall_held, clk, rst_n, data_stall, in_valid_reg && emit)

endmodule
